>>> rtl/rprop_weight_update_top_assert.svh
// Assertion macros for the module that checks its own logic.
`ifndef RPROP_WEIGHT_UPDATE_TOP_ASSERT_SVH
`define RPROP_WEIGHT_UPDATE_TOP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RWU_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define RWU_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/rwu_pkg.sv
package rwu_pkg;

    localparam int IDX_W = 10;

    localparam logic [2:0] CFG_ETA_PLUS  = 3'd0;
    localparam logic [2:0] CFG_ETA_MINUS = 3'd1;
    localparam logic [2:0] CFG_STEP_MAX  = 3'd2;
    localparam logic [2:0] CFG_STEP_MIN  = 3'd3;
    localparam logic [2:0] CFG_INIT_STEP = 3'd4;
    localparam logic [2:0] CFG_ZERO_BAND = 3'd5;

    localparam logic [15:0] ETA_PLUS_RST  = 16'd4915;
    localparam logic [12:0] ETA_MINUS_RST = 13'd2048;
    localparam logic [30:0] STEP_MAX_RST  = 31'd838860800;
    localparam logic [30:0] STEP_MIN_RST  = 31'd17;
    localparam logic [30:0] INIT_STEP_RST = 31'd167772;
    localparam logic [15:0] ZERO_BAND_RST = 16'd0;

    localparam logic [30:0] STEP_SAT = 31'h7FFF_FFFF;

    localparam logic [1:0] SIGN_ZERO = 2'd0;
    localparam logic [1:0] SIGN_POS  = 2'd1;
    localparam logic [1:0] SIGN_NEG  = 2'd2;
    localparam logic [1:0] SIGN_RSVD = 2'd3;

    localparam logic [1:0] KIND_KEPT = 2'd0;
    localparam logic [1:0] KIND_FLIP = 2'd1;
    localparam logic [1:0] KIND_HOLD = 2'd2;

    localparam logic REQ_LOAD   = 1'b0;
    localparam logic REQ_UPDATE = 1'b1;

    typedef struct packed {
        logic [31:0] weight;
        logic [30:0] step;
        logic [1:0]  sign;
    } rwu_entry_t;

    typedef struct packed {
        logic             req_type;
        logic [IDX_W-1:0] out_index;
        logic [31:0]      value;
        logic [31:0]      weight;
        logic [30:0]      old_step;
        logic [1:0]       new_sign;
        logic [1:0]       kind;
        logic [46:0]      prod;
    } rwu_stage_t;

endpackage

>>> rtl/rwu_ram.sv
module rwu_ram #(
    parameter int DEPTH = 1024,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic               aclk,
    input  logic               we,
    input  logic [AW-1:0]      waddr,
    input  rwu_pkg::rwu_entry_t wdata,
    input  logic               re,
    input  logic [AW-1:0]      raddr,
    output rwu_pkg::rwu_entry_t rdata
);

    rwu_pkg::rwu_entry_t mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

>>> rtl/rwu_operand.sv
module rwu_operand (
    input  logic                          req_type,
    input  logic [rwu_pkg::IDX_W-1:0]     out_index,
    input  logic [31:0]                   value,
    input  rwu_pkg::rwu_entry_t           entry,
    input  logic [15:0]                   eta_plus,
    input  logic [12:0]                   eta_minus,
    input  logic [15:0]                   zero_band,
    output rwu_pkg::rwu_stage_t           stage
);

    logic [1:0]  prev_sign;
    logic [1:0]  new_sign;
    logic [31:0] grad_mag;
    logic [1:0]  kind;
    logic [15:0] eta;

    always_comb begin
        prev_sign = (entry.sign == rwu_pkg::SIGN_RSVD) ? rwu_pkg::SIGN_ZERO : entry.sign;
        grad_mag  = value[31] ? (32'd0 - value) : value;
        if (grad_mag <= {16'd0, zero_band}) begin
            new_sign = rwu_pkg::SIGN_ZERO;
        end else if (value[31]) begin
            new_sign = rwu_pkg::SIGN_NEG;
        end else begin
            new_sign = rwu_pkg::SIGN_POS;
        end

        if (prev_sign == rwu_pkg::SIGN_ZERO || new_sign == rwu_pkg::SIGN_ZERO) begin
            kind = rwu_pkg::KIND_HOLD;
        end else if (prev_sign == new_sign) begin
            kind = rwu_pkg::KIND_KEPT;
        end else begin
            kind = rwu_pkg::KIND_FLIP;
        end

        eta = (kind == rwu_pkg::KIND_KEPT) ? eta_plus : {3'd0, eta_minus};

        stage.req_type  = req_type;
        stage.out_index = out_index;
        stage.value     = value;
        stage.weight    = entry.weight;
        stage.old_step  = entry.step;
        stage.new_sign  = new_sign;
        stage.kind      = kind;
        stage.prod      = 47'(entry.step) * 47'(eta);
    end

endmodule

>>> rtl/rwu_update.sv
module rwu_update (
    input  rwu_pkg::rwu_stage_t stage,
    input  logic [30:0]         step_max,
    input  logic [30:0]         step_min,
    input  logic [30:0]         init_step,
    output rwu_pkg::rwu_entry_t result
);

    logic [34:0] scaled;
    logic [34:0] clamp_in;
    logic [30:0] clamped;
    logic [30:0] shrunk;
    logic [30:0] step_new;
    logic [30:0] move_mag;
    logic        move_sub;
    logic [33:0] wide_w;
    logic [33:0] sum;
    logic [31:0] sat_w;
    logic [1:0]  sign_new;

    always_comb begin
        scaled   = stage.prod[46:12];
        clamp_in = (stage.kind == rwu_pkg::KIND_HOLD) ? {4'd0, stage.old_step} : scaled;

        if (clamp_in > {4'd0, step_max}) begin
            clamped = step_max;
        end else if (clamp_in < {4'd0, step_min}) begin
            clamped = step_min;
        end else begin
            clamped = clamp_in[30:0];
        end

        shrunk = (scaled > {4'd0, rwu_pkg::STEP_SAT}) ? rwu_pkg::STEP_SAT : scaled[30:0];
        if (shrunk < step_min) begin
            shrunk = step_min;
        end

        move_mag = 31'd0;
        move_sub = 1'b0;
        case (stage.kind)
            rwu_pkg::KIND_KEPT: begin
                step_new = clamped;
                sign_new = stage.new_sign;
                move_mag = clamped;
                move_sub = (stage.new_sign == rwu_pkg::SIGN_POS);
            end
            rwu_pkg::KIND_FLIP: begin
                step_new = shrunk;
                sign_new = rwu_pkg::SIGN_ZERO;
                move_mag = stage.old_step;
                move_sub = 1'b1;
            end
            default: begin
                step_new = clamped;
                sign_new = stage.new_sign;
                if (stage.new_sign != rwu_pkg::SIGN_ZERO) begin
                    move_mag = clamped;
                end
                move_sub = (stage.new_sign == rwu_pkg::SIGN_POS);
            end
        endcase

        wide_w = {{2{stage.weight[31]}}, stage.weight};
        sum    = move_sub ? (wide_w - {3'd0, move_mag}) : (wide_w + {3'd0, move_mag});
        if (sum[33:31] == 3'b000 || sum[33:31] == 3'b111) begin
            sat_w = sum[31:0];
        end else if (sum[33]) begin
            sat_w = 32'h8000_0000;
        end else begin
            sat_w = 32'h7FFF_FFFF;
        end

        if (stage.req_type == rwu_pkg::REQ_LOAD) begin
            result.weight = stage.value;
            result.step   = init_step;
            result.sign   = rwu_pkg::SIGN_ZERO;
        end else begin
            result.weight = sat_w;
            result.step   = step_new;
            result.sign   = sign_new;
        end
    end

endmodule

>>> rtl/rprop_weight_update_top.sv
// Channel   Direction  Handshake                Payload
// s_        in         s_valid / s_ready        s_req_type, s_elem_index, s_value
// m_        out        m_valid / m_ready        m_out_index, m_new_weight, m_new_step,
//                                               m_grad_sign
// cfg_      in         cfg_valid / cfg_ready    cfg_index, cfg_data
//
// One transaction per cycle unless a hazard or stall holds it; results pass the read and
// update stages to the output register. An update to the element in the read stage waits until
// it is written; one to the element written on its accepting edge reads it from a bypass register.
// Reset clears the pipeline and loads the register defaults; the state memory is not cleared.
// While m_ready is low the output holds and up to two more transactions are taken.
`include "rprop_weight_update_top_assert.svh"

module rprop_weight_update_top #(
    parameter int ELEMENTS = 1024
) (
    input  logic                      aclk,
    input  logic                      aresetn,

    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic                      s_req_type,
    input  logic [rwu_pkg::IDX_W-1:0] s_elem_index,
    input  logic signed [31:0]        s_value,

    output logic                      m_valid,
    input  logic                      m_ready,
    output logic [rwu_pkg::IDX_W-1:0] m_out_index,
    output logic signed [31:0]        m_new_weight,
    output logic [30:0]               m_new_step,
    output logic [1:0]                m_grad_sign,

    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [2:0]                cfg_index,
    input  logic [31:0]               cfg_data
);

    localparam int AW = (ELEMENTS > 1) ? $clog2(ELEMENTS) : 1;

    logic [15:0] eta_plus_reg;
    logic [12:0] eta_minus_reg;
    logic [30:0] step_max_reg;
    logic [30:0] step_min_reg;
    logic [30:0] init_step_reg;
    logic [15:0] zero_band_reg;

    logic [rwu_pkg::IDX_W-1:0] fold;
    logic [AW-1:0]             addr_in;
    logic                      accept;
    logic                      hazard;

    logic                      s1_valid_reg;
    logic                      s1_valid_next;
    logic [AW-1:0]             s1_addr_reg;
    logic                      s1_req_reg;
    logic [rwu_pkg::IDX_W-1:0] s1_index_reg;
    logic [31:0]               s1_value_reg;
    logic                      byp_hit_reg;
    rwu_pkg::rwu_entry_t       byp_data_reg;
    rwu_pkg::rwu_entry_t       rd_data;
    rwu_pkg::rwu_entry_t       s1_entry;
    rwu_pkg::rwu_stage_t       s1_stage;

    logic                      s2_valid_reg;
    logic                      s2_valid_next;
    logic [AW-1:0]             s2_addr_reg;
    rwu_pkg::rwu_stage_t       s2_stage_reg;
    rwu_pkg::rwu_entry_t       wr_data;

    logic                      m_valid_reg;
    logic                      m_valid_next;
    logic                      out_free;
    logic                      s2_move;
    logic                      s1_move;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            eta_plus_reg  <= rwu_pkg::ETA_PLUS_RST;
            eta_minus_reg <= rwu_pkg::ETA_MINUS_RST;
            step_max_reg  <= rwu_pkg::STEP_MAX_RST;
            step_min_reg  <= rwu_pkg::STEP_MIN_RST;
            init_step_reg <= rwu_pkg::INIT_STEP_RST;
            zero_band_reg <= rwu_pkg::ZERO_BAND_RST;
        end else if (cfg_valid) begin
            case (cfg_index)
                rwu_pkg::CFG_ETA_PLUS:  eta_plus_reg  <= cfg_data[15:0];
                rwu_pkg::CFG_ETA_MINUS: eta_minus_reg <= cfg_data[12:0];
                rwu_pkg::CFG_STEP_MAX:  step_max_reg  <= cfg_data[30:0];
                rwu_pkg::CFG_STEP_MIN:  step_min_reg  <= cfg_data[30:0];
                rwu_pkg::CFG_INIT_STEP: init_step_reg <= cfg_data[30:0];
                rwu_pkg::CFG_ZERO_BAND: zero_band_reg <= cfg_data[15:0];
                default: begin
                end
            endcase
        end
    end

    // Fold the index into the memory range by conditional subtraction of shifted depths.
    always_comb begin
        fold = s_elem_index;
        for (int k = rwu_pkg::IDX_W - 1; k >= 0; k--) begin
            if (32'(fold) >= (32'(ELEMENTS) << k)) begin
                fold = fold - rwu_pkg::IDX_W'(32'(ELEMENTS) << k);
            end
        end
        addr_in = AW'(fold);
    end

    assign out_free = !m_valid_reg || m_ready;
    assign s2_move  = s2_valid_reg && out_free;
    assign s1_move  = s1_valid_reg && (!s2_valid_reg || s2_move);

    assign hazard = (s_req_type == rwu_pkg::REQ_UPDATE) &&
                    ((s1_valid_reg && addr_in == s1_addr_reg) ||
                     (s2_valid_reg && addr_in == s2_addr_reg && !s2_move));
    assign s_ready = (!s1_valid_reg || s1_move) && !hazard;
    assign accept  = s_valid && s_ready;

    rwu_ram #(
        .DEPTH (ELEMENTS)
    ) u_ram (
        .aclk  (aclk),
        .we    (s2_move),
        .waddr (s2_addr_reg),
        .wdata (wr_data),
        .re    (accept),
        .raddr (addr_in),
        .rdata (rd_data)
    );

    assign s1_valid_next = accept || (s1_valid_reg && !s1_move);
    assign s2_valid_next = s1_move || (s2_valid_reg && !s2_move);
    assign m_valid_next  = s2_move || (m_valid_reg && !m_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            s1_valid_reg <= s1_valid_next;
            s2_valid_reg <= s2_valid_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_addr_reg  <= addr_in;
            s1_req_reg   <= s_req_type;
            s1_index_reg <= s_elem_index;
            s1_value_reg <= s_value;
            byp_hit_reg  <= s2_move && (s2_addr_reg == addr_in);
            byp_data_reg <= wr_data;
        end
        if (s1_move) begin
            s2_addr_reg  <= s1_addr_reg;
            s2_stage_reg <= s1_stage;
        end
        if (s2_move) begin
            m_out_index  <= s2_stage_reg.out_index;
            m_new_weight <= wr_data.weight;
            m_new_step   <= wr_data.step;
            m_grad_sign  <= wr_data.sign;
        end
    end

    assign s1_entry = byp_hit_reg ? byp_data_reg : rd_data;

    rwu_operand u_operand (
        .req_type  (s1_req_reg),
        .out_index (s1_index_reg),
        .value     (s1_value_reg),
        .entry     (s1_entry),
        .eta_plus  (eta_plus_reg),
        .eta_minus (eta_minus_reg),
        .zero_band (zero_band_reg),
        .stage     (s1_stage)
    );

    rwu_update u_update (
        .stage     (s2_stage_reg),
        .step_max  (step_max_reg),
        .step_min  (step_min_reg),
        .init_step (init_step_reg),
        .result    (wr_data)
    );

    assign m_valid = m_valid_reg;

    `RWU_ASSERT_SAME(a_no_raw_in_read_stage,
        accept && s_req_type == rwu_pkg::REQ_UPDATE,
        !(s1_valid_reg && addr_in == s1_addr_reg),
        "An update was accepted for the element held in the read stage.")
    `RWU_ASSERT_NEXT(a_bypass_on_same_edge_write,
        accept && s2_move && s2_addr_reg == addr_in,
        byp_hit_reg,
        "A write on the read edge was not captured for bypass.")
    `RWU_ASSERT_NEXT(a_write_reaches_output,
        s2_move,
        m_valid_reg && m_new_step == $past(wr_data.step),
        "A written result did not reach the output register.")
    `RWU_ASSERT_SAME(a_sign_code_legal,
        m_valid_reg,
        m_grad_sign != rwu_pkg::SIGN_RSVD,
        "The output carries an undefined sign code.")

endmodule
